// ----- design/cnls_pkg.sv -----
// types, codes and constants shared by the numeric literal scanner
// used by cnls_step and c_numeric_literal_scanner_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cnls_pkg;

  // default fraction digit limit
  localparam int unsigned MaxFracDigitsDef = 19;

  localparam int unsigned AccumW     = 64;
  localparam int unsigned FracCountW = 5;
  localparam int unsigned SeenW      = 2;

  // character codes
  localparam logic [7:0] ChZero  = 8'd48;
  localparam logic [7:0] ChNine  = 8'd57;
  localparam logic [7:0] ChSeven = 8'd55;
  localparam logic [7:0] ChDot   = 8'd46;
  localparam logic [7:0] ChUpA   = 8'd65;
  localparam logic [7:0] ChUpZ   = 8'd90;
  localparam logic [7:0] ChLoA   = 8'd97;
  localparam logic [7:0] ChLoF   = 8'd102;
  localparam logic [7:0] ChLoL   = 8'd108;
  localparam logic [7:0] ChLoU   = 8'd117;
  localparam logic [7:0] ChLoX   = 8'd120;
  localparam logic [7:0] CaseGap = 8'd32;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_ZERO   = 7'b0000010,
    PH_HEX    = 7'b0000100,
    PH_OCT    = 7'b0001000,
    PH_DEC    = 7'b0010000,
    PH_FRAC   = 7'b0100000,
    PH_SUFFIX = 7'b1000000
  } phase_e;

  typedef enum logic [2:0] {
    KIND_INT     = 3'd0,
    KIND_UINT    = 3'd1,
    KIND_LONG    = 3'd2,
    KIND_ULONG   = 3'd3,
    KIND_DOUBLE  = 3'd4,
    KIND_FLOAT   = 3'd5,
    KIND_LDOUBLE = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_BAD_SUFFIX = 2'd1,
    ERR_UNTERM     = 2'd2
  } err_e;

  typedef struct packed {
    phase_e                phase;
    logic [AccumW-1:0]     accum;
    logic [AccumW-1:0]     frac_accum;
    logic [FracCountW-1:0] frac_count;
    logic [SeenW-1:0]      u_seen;
    logic [SeenW-1:0]      l_seen;
  } scan_state_t;

  typedef struct packed {
    kind_e                 kind;
    logic [AccumW-1:0]     int_part;
    logic [AccumW-1:0]     frac_value;
    logic [FracCountW-1:0] frac_digits;
    err_e                  error;
    logic                  took_char;
  } scan_result_t;

endpackage

`default_nettype wire

// ----- design/c_numeric_literal_scanner_core.sv -----
// top level of the C numeric literal scanner: stream ports, input and result registers
// depends on cnls_pkg and cnls_step
`timescale 1ns / 1ps
`default_nettype none

// Scans C integer and real literals from a byte stream, one source character per
// request. Each accepted request is one byte (tdata) plus an end-of-text flag
// (tuser) meaning "no byte, the text ends here". When a literal closes, one result
// request comes out with its kind, 64-bit integer part, fraction numerator and
// digit count, error code and whether the closing byte was part of the literal.
// Throughput is one character per clock while no closing character waits on a full
// result slot: the whole per-character step (a times-ten add for the integer and the
// fraction, suffix counting, kind choice) is one layer of logic between the input
// register and the state/result registers, so the scan state loops back directly.
// An accepted character waits in the input register and the result it closes in
// the result register. The input side keeps taking characters while a result waits
// on the output as long as the held character does not close another literal.

module c_numeric_literal_scanner_core #(
  parameter int unsigned MaxFracDigits = cnls_pkg::MaxFracDigitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input characters
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] ch
  input  logic         s_axis_tuser_i,   // [0] end_of_text
  // literal results
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [63:0] int_part, [127:64] frac_value, [132:128] frac_digits,
  // [134:133] error, [135] took_char
  output logic [135:0] m_axis_tdata_o,
  output logic [2:0]   m_axis_tuser_o    // [2:0] kind
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_ch_q;
  logic       in_eot_q;

  // scan state
  cnls_pkg::scan_state_t state_q, state_d;

  // result register
  logic                   out_valid_q, out_valid_d;
  cnls_pkg::scan_result_t out_res_q;

  logic                   step_valid;
  cnls_pkg::scan_result_t step_res;
  logic                   out_free;
  logic                   advance;

  cnls_step #(
    .MaxFracDigits(MaxFracDigits)
  ) u_step (
    .state_i    (state_q),
    .ch_i       (in_ch_q),
    .eot_i      (in_eot_q),
    .state_o    (state_d),
    .res_valid_o(step_valid),
    .res_o      (step_res)
  );

  // the held character moves on unless it closes a literal and the result slot is full
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && (!step_valid || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready_o) in_valid_d = s_axis_tvalid_i;
    out_valid_d = out_valid_q;
    if (advance && step_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
      state_q.phase      <= cnls_pkg::PH_IDLE;
      state_q.accum      <= '0;
      state_q.frac_accum <= '0;
      state_q.frac_count <= '0;
      state_q.u_seen     <= '0;
      state_q.l_seen     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) state_q <= state_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_ch_q  <= s_axis_tdata_i;
      in_eot_q <= s_axis_tuser_i;
    end
    if (advance && step_valid) out_res_q <= step_res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.kind;
  assign m_axis_tdata_o  = {out_res_q.took_char, out_res_q.error, out_res_q.frac_digits,
                            out_res_q.frac_value, out_res_q.int_part};

endmodule

`default_nettype wire

// ----- design/cnls_step.sv -----
// next-state and result logic for one character of the literal scanner
// depends on cnls_pkg
`timescale 1ns / 1ps
`default_nettype none

module cnls_step #(
  parameter int unsigned MaxFracDigits = cnls_pkg::MaxFracDigitsDef
) (
  input  cnls_pkg::scan_state_t  state_i,
  input  logic [7:0]             ch_i,
  input  logic                   eot_i,
  output cnls_pkg::scan_state_t  state_o,
  output logic                   res_valid_o,
  output cnls_pkg::scan_result_t res_o
);

  logic [7:0]  lc;
  logic        is_dig;
  logic        is_oct;
  logic        is_hexl;
  logic        is_u;
  logic        is_l;
  logic [3:0]  dig;
  logic [3:0]  hex_val;
  logic [63:0] acc10;
  logic [63:0] frac10;
  logic [63:0] acc16_dig;
  logic [63:0] acc16_hex;
  logic [63:0] acc8;
  logic        do_oct;
  logic        do_suffix;
  logic        end_wide;

  always_comb begin
    lc = ((ch_i >= cnls_pkg::ChUpA) && (ch_i <= cnls_pkg::ChUpZ)) ?
         ch_i + cnls_pkg::CaseGap : ch_i;
    is_dig  = !eot_i && (ch_i >= cnls_pkg::ChZero) && (ch_i <= cnls_pkg::ChNine);
    is_oct  = !eot_i && (ch_i >= cnls_pkg::ChZero) && (ch_i <= cnls_pkg::ChSeven);
    is_hexl = !eot_i && (lc >= cnls_pkg::ChLoA) && (lc <= cnls_pkg::ChLoF);
    is_u    = !eot_i && (lc == cnls_pkg::ChLoU);
    is_l    = !eot_i && (lc == cnls_pkg::ChLoL);
    dig     = ch_i[3:0];
    // 'a'..'f' have low nibble 1..6
    hex_val = lc[3:0] + 4'd9;
  end

  // times ten as two shifts and one add
  assign acc10 = {state_i.accum[60:0], 3'b000} + {state_i.accum[62:0], 1'b0}
                 + {60'd0, dig};
  assign frac10 = {state_i.frac_accum[60:0], 3'b000}
                  + {state_i.frac_accum[62:0], 1'b0} + {60'd0, dig};
  assign acc16_dig = {state_i.accum[59:0], dig};
  assign acc16_hex = {state_i.accum[59:0], hex_val};
  assign acc8      = {state_i.accum[60:0], dig[2:0]};

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o.kind        = cnls_pkg::KIND_INT;
    res_o.int_part    = state_i.accum;
    res_o.frac_value  = '0;
    res_o.frac_digits = '0;
    res_o.error       = cnls_pkg::ERR_NONE;
    res_o.took_char   = 1'b0;
    do_oct    = 1'b0;
    do_suffix = 1'b0;
    end_wide  = 1'b0;

    case (state_i.phase)
      cnls_pkg::PH_ZERO: begin
        if (!eot_i && (lc == cnls_pkg::ChLoX)) begin
          state_o.phase = cnls_pkg::PH_HEX;
        end else begin
          do_oct = 1'b1;
        end
      end
      cnls_pkg::PH_HEX: begin
        if (is_dig) begin
          state_o.accum = acc16_dig;
        end else if (is_hexl) begin
          state_o.accum = acc16_hex;
        end else begin
          end_wide = 1'b1;
        end
      end
      cnls_pkg::PH_OCT: begin
        do_oct = 1'b1;
      end
      cnls_pkg::PH_DEC: begin
        if (is_dig) begin
          state_o.accum = acc10;
        end else if (!eot_i && (ch_i == cnls_pkg::ChDot)) begin
          state_o.phase = cnls_pkg::PH_FRAC;
        end else begin
          do_suffix = 1'b1;
        end
      end
      cnls_pkg::PH_FRAC: begin
        res_o.frac_value  = state_i.frac_accum;
        res_o.frac_digits = state_i.frac_count;
        if (eot_i) begin
          res_valid_o = 1'b1;
          res_o.kind  = cnls_pkg::KIND_DOUBLE;
          res_o.error = cnls_pkg::ERR_UNTERM;
        end else if (is_dig) begin
          // extra digits are dropped
          if (state_i.frac_count < cnls_pkg::FracCountW'(MaxFracDigits)) begin
            state_o.frac_accum = frac10;
            state_o.frac_count = state_i.frac_count + 1'b1;
          end
        end else if (is_l) begin
          res_valid_o     = 1'b1;
          res_o.kind      = cnls_pkg::KIND_LDOUBLE;
          res_o.took_char = 1'b1;
        end else if (lc == cnls_pkg::ChLoF) begin
          res_valid_o     = 1'b1;
          res_o.kind      = cnls_pkg::KIND_FLOAT;
          res_o.took_char = 1'b1;
        end else begin
          res_valid_o = 1'b1;
          res_o.kind  = cnls_pkg::KIND_DOUBLE;
        end
      end
      cnls_pkg::PH_SUFFIX: begin
        do_suffix = 1'b1;
      end
      default: begin
        state_o.phase = cnls_pkg::PH_IDLE;
      end
    endcase

    // octal digits, a zero value falling into the suffix run, or a nonzero value closing
    if (do_oct) begin
      state_o.phase = cnls_pkg::PH_OCT;
      if (is_oct) begin
        state_o.accum = acc8;
      end else if (state_i.accum == '0) begin
        do_suffix = 1'b1;
      end else begin
        end_wide = 1'b1;
      end
    end

    if (do_suffix) begin
      state_o.phase = cnls_pkg::PH_SUFFIX;
      if (is_u) begin
        if (state_i.u_seen != 2'd3) state_o.u_seen = state_i.u_seen + 1'b1;
      end else if (is_l) begin
        if (state_i.l_seen != 2'd3) state_o.l_seen = state_i.l_seen + 1'b1;
      end else begin
        res_valid_o = 1'b1;
        if ((state_i.u_seen > 2'd1) || (state_i.l_seen > 2'd2)) begin
          res_o.error = cnls_pkg::ERR_BAD_SUFFIX;
        end else if (state_i.u_seen != '0) begin
          res_o.kind = (state_i.l_seen != '0) ? cnls_pkg::KIND_ULONG : cnls_pkg::KIND_UINT;
        end else begin
          res_o.kind = (state_i.l_seen != '0) ? cnls_pkg::KIND_LONG : cnls_pkg::KIND_INT;
        end
      end
    end

    // long when positive as signed 64-bit and above the 32-bit int range
    if (end_wide) begin
      res_valid_o = 1'b1;
      res_o.kind  = (!state_i.accum[63] && (|state_i.accum[62:31])) ?
                    cnls_pkg::KIND_LONG : cnls_pkg::KIND_INT;
    end

    if (res_valid_o) begin
      state_o.phase = cnls_pkg::PH_IDLE;
    end

    // a digit in idle, or an unconsumed ending digit, opens a literal
    if ((state_o.phase == cnls_pkg::PH_IDLE) && !res_o.took_char && is_dig) begin
      state_o.phase      = (ch_i == cnls_pkg::ChZero) ? cnls_pkg::PH_ZERO : cnls_pkg::PH_DEC;
      state_o.accum      = {60'd0, dig};
      state_o.frac_accum = '0;
      state_o.frac_count = '0;
      state_o.u_seen     = '0;
      state_o.l_seen     = '0;
    end
  end

endmodule

`default_nettype wire

// ----- sim/c_numeric_literal_scanner_core_tb.sv -----
// self-checking testbench for c_numeric_literal_scanner_core: directed table, then random text
// depends on cnls_pkg and the scanner core; own scan predictor, no files or arguments
`timescale 1ns / 1ps

module c_numeric_literal_scanner_core_tb;

  localparam int unsigned FracLimit = cnls_pkg::MaxFracDigitsDef;
  localparam int unsigned BusyGoal  = 1850;
  localparam int unsigned MaxShown  = 10;

  typedef struct {
    logic [7:0]             ch;
    bit                     eot;
    bit                     typed;
    cnls_pkg::scan_result_t res;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = 8'd0;
  logic         s_axis_tuser_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [135:0] m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;

  // typed expectation travelling with the request on the wire
  bit                     row_typed = 1'b0;
  cnls_pkg::scan_result_t row_res = '0;

  // scan predictor state
  cnls_pkg::phase_e       scan_phase = cnls_pkg::PH_IDLE;
  logic [63:0]            int_acc = '0;
  logic [63:0]            frac_acc = '0;
  logic [4:0]             frac_cnt = '0;
  logic [1:0]             u_cnt = '0;
  logic [1:0]             l_cnt = '0;
  bit                     lit_hit;
  cnls_pkg::scan_result_t lit_out;

  cnls_pkg::scan_result_t pending_literals[$];
  stim_row_t              char_table[$];
  logic [8:0]             text_q[$];   // [8] end of text, [7:0] byte
  int unsigned            busy_items = 0;
  int unsigned            bad_count = 0;
  int unsigned            burst_left = 0;

  c_numeric_literal_scanner_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= cnls_pkg::ChUpA && c <= cnls_pkg::ChUpZ) ? c + cnls_pkg::CaseGap : c;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= cnls_pkg::ChZero && c <= cnls_pkg::ChNine;
  endfunction

  function automatic void lit_close(cnls_pkg::kind_e k, logic [63:0] fv, logic [4:0] fd,
                                    cnls_pkg::err_e e, bit took);
    lit_hit             = 1'b1;
    lit_out.kind        = k;
    lit_out.int_part    = int_acc;
    lit_out.frac_value  = fv;
    lit_out.frac_digits = fd;
    lit_out.error       = e;
    lit_out.took_char   = took;
    scan_phase          = cnls_pkg::PH_IDLE;
  endfunction

  function automatic void lit_open(logic [7:0] c);
    int_acc  = '0;
    frac_acc = '0;
    frac_cnt = '0;
    u_cnt    = '0;
    l_cnt    = '0;
    if (c == cnls_pkg::ChZero) begin
      scan_phase = cnls_pkg::PH_ZERO;
    end else begin
      scan_phase = cnls_pkg::PH_DEC;
      int_acc    = {56'd0, c - cnls_pkg::ChZero};
    end
  endfunction

  // hex and nonzero octal: long only when positive as signed and above int max
  function automatic void close_sized();
    if (int_acc > 64'd2147483647 && !int_acc[63])
      lit_close(cnls_pkg::KIND_LONG, '0, '0, cnls_pkg::ERR_NONE, 1'b0);
    else
      lit_close(cnls_pkg::KIND_INT, '0, '0, cnls_pkg::ERR_NONE, 1'b0);
  endfunction

  function automatic void take_suffix(logic [7:0] c, bit eot);
    logic [7:0] lc;
    lc = fold_case(c);
    scan_phase = cnls_pkg::PH_SUFFIX;
    if (!eot && lc == cnls_pkg::ChLoU) begin
      if (u_cnt < 2'd3) u_cnt = u_cnt + 2'd1;
    end else if (!eot && lc == cnls_pkg::ChLoL) begin
      if (l_cnt < 2'd3) l_cnt = l_cnt + 2'd1;
    end else if (u_cnt > 2'd1 || l_cnt > 2'd2) begin
      lit_close(cnls_pkg::KIND_INT, '0, '0, cnls_pkg::ERR_BAD_SUFFIX, 1'b0);
    end else if (u_cnt != 2'd0) begin
      lit_close((l_cnt != 2'd0) ? cnls_pkg::KIND_ULONG : cnls_pkg::KIND_UINT, '0, '0,
                cnls_pkg::ERR_NONE, 1'b0);
    end else begin
      lit_close((l_cnt != 2'd0) ? cnls_pkg::KIND_LONG : cnls_pkg::KIND_INT, '0, '0,
                cnls_pkg::ERR_NONE, 1'b0);
    end
  endfunction

  function automatic void take_octal(logic [7:0] c, bit eot);
    scan_phase = cnls_pkg::PH_OCT;
    if (!eot && c >= cnls_pkg::ChZero && c <= cnls_pkg::ChSeven)
      int_acc = int_acc * 64'd8 + {56'd0, c - cnls_pkg::ChZero};
    else if (int_acc == '0)
      take_suffix(c, eot);   // zero octal may carry a suffix run
    else
      close_sized();
  endfunction

  function automatic void predict_char(logic [7:0] c, bit eot);
    logic [7:0] lc;
    lc = fold_case(c);
    lit_hit = 1'b0;
    case (scan_phase)
      cnls_pkg::PH_ZERO: begin
        if (!eot && lc == cnls_pkg::ChLoX) scan_phase = cnls_pkg::PH_HEX;
        else take_octal(c, eot);
      end
      cnls_pkg::PH_HEX: begin
        if (!eot && is_digit(c))
          int_acc = int_acc * 64'd16 + {56'd0, c - cnls_pkg::ChZero};
        else if (!eot && lc >= cnls_pkg::ChLoA && lc <= cnls_pkg::ChLoF)
          int_acc = int_acc * 64'd16 + {56'd0, lc - cnls_pkg::ChLoA + 8'd10};
        else
          close_sized();
      end
      cnls_pkg::PH_OCT: take_octal(c, eot);
      cnls_pkg::PH_DEC: begin
        if (!eot && is_digit(c))
          int_acc = int_acc * 64'd10 + {56'd0, c - cnls_pkg::ChZero};
        else if (!eot && c == cnls_pkg::ChDot)
          scan_phase = cnls_pkg::PH_FRAC;
        else
          take_suffix(c, eot);
      end
      cnls_pkg::PH_FRAC: begin
        if (eot) begin
          lit_close(cnls_pkg::KIND_DOUBLE, frac_acc, frac_cnt, cnls_pkg::ERR_UNTERM, 1'b0);
        end else if (is_digit(c)) begin
          // digits past the limit are dropped
          if (frac_cnt < FracLimit) begin
            frac_acc = frac_acc * 64'd10 + {56'd0, c - cnls_pkg::ChZero};
            frac_cnt = frac_cnt + 5'd1;
          end
        end else if (lc == cnls_pkg::ChLoL) begin
          lit_close(cnls_pkg::KIND_LDOUBLE, frac_acc, frac_cnt, cnls_pkg::ERR_NONE, 1'b1);
        end else if (lc == cnls_pkg::ChLoF) begin
          lit_close(cnls_pkg::KIND_FLOAT, frac_acc, frac_cnt, cnls_pkg::ERR_NONE, 1'b1);
        end else begin
          lit_close(cnls_pkg::KIND_DOUBLE, frac_acc, frac_cnt, cnls_pkg::ERR_NONE, 1'b0);
        end
      end
      cnls_pkg::PH_SUFFIX: take_suffix(c, eot);
      default: begin
        scan_phase = cnls_pkg::PH_IDLE;
        if (!eot && is_digit(c)) lit_open(c);
      end
    endcase
    // a digit that closed a literal without being taken opens the next one
    if (lit_hit && !lit_out.took_char && !eot && is_digit(c)) lit_open(c);
  endfunction

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin : watch
    cnls_pkg::phase_e       prior;
    cnls_pkg::scan_result_t got;
    cnls_pkg::scan_result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        prior = scan_phase;
        predict_char(s_axis_tdata_i, s_axis_tuser_i);
        if (prior != cnls_pkg::PH_IDLE || scan_phase != cnls_pkg::PH_IDLE || lit_hit)
          busy_items++;
        if (row_typed) pending_literals.insert(pending_literals.size(), row_res);
        else if (lit_hit) pending_literals.insert(pending_literals.size(), lit_out);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.kind        = cnls_pkg::kind_e'(m_axis_tuser_o);
        got.int_part    = m_axis_tdata_o[63:0];
        got.frac_value  = m_axis_tdata_o[127:64];
        got.frac_digits = m_axis_tdata_o[132:128];
        got.error       = cnls_pkg::err_e'(m_axis_tdata_o[134:133]);
        got.took_char   = m_axis_tdata_o[135];
        if (pending_literals.size() == 0) begin
          bad_count++;
          if (bad_count <= MaxShown)
            $display({"unexpected literal result: kind %0d int %h frac %0d/%0d ",
                      "err %0d took %0d"},
                     got.kind, got.int_part, got.frac_value, got.frac_digits, got.error,
                     got.took_char);
        end else begin
          want = pending_literals[0];
          pending_literals.delete(0);
          if (got.kind !== want.kind || got.int_part !== want.int_part ||
              got.frac_value !== want.frac_value || got.frac_digits !== want.frac_digits ||
              got.error !== want.error || got.took_char !== want.took_char) begin
            bad_count++;
            if (bad_count <= MaxShown)
              $display({"literal mismatch: expected kind %0d int %h frac %0d/%0d err %0d ",
                        "took %0d, got kind %0d int %h frac %0d/%0d err %0d took %0d"},
                       want.kind, want.int_part, want.frac_value, want.frac_digits,
                       want.error, want.took_char, got.kind, got.int_part, got.frac_value,
                       got.frac_digits, got.error, got.took_char);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  function automatic void tab(logic [7:0] ch, bit eot);
    stim_row_t r;
    r.ch    = ch;
    r.eot   = eot;
    r.typed = 1'b0;
    r.res   = '0;
    char_table.insert(char_table.size(), r);
  endfunction

  function automatic void tab_close(logic [7:0] ch, bit eot, cnls_pkg::kind_e k,
                                    logic [63:0] ip, logic [63:0] fv, logic [4:0] fd,
                                    cnls_pkg::err_e e, bit took);
    stim_row_t r;
    r.ch                = ch;
    r.eot               = eot;
    r.typed             = 1'b1;
    r.res.kind          = k;
    r.res.int_part      = ip;
    r.res.frac_value    = fv;
    r.res.frac_digits   = fd;
    r.res.error         = e;
    r.res.took_char     = took;
    char_table.insert(char_table.size(), r);
  endfunction

  function automatic void put(logic [7:0] c);
    text_q.insert(text_q.size(), {1'b0, c});
  endfunction

  function automatic void put_eot();
    text_q.insert(text_q.size(), {1'b1, 8'($urandom_range(0, 255))});
  endfunction

  function automatic logic [7:0] mix_case(logic [7:0] c);
    return $urandom_range(0, 1) ? c - cnls_pkg::CaseGap : c;
  endfunction

  function automatic void put_suffixes(int n);
    repeat (n) put(mix_case($urandom_range(0, 1) ? cnls_pkg::ChLoU : cnls_pkg::ChLoL));
  endfunction

  // whatever follows a literal in running text
  function automatic void put_ender();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) put_eot();
    else if (r < 30) put(8'h20);
    else if (r < 40) put(";");
    else if (r < 50) put(")");
    else if (r < 62) put(8'(cnls_pkg::ChZero + $urandom_range(0, 9)));
    else if (r < 70) put(cnls_pkg::ChDot);
    else if (r < 78) put(mix_case(8'(cnls_pkg::ChLoA + $urandom_range(0, 25))));
    else put(8'($urandom_range(0, 255)));
  endfunction

  function automatic void make_literal();
    int sel;
    int n;
    int v;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      // decimal integer with optional suffix run, sometimes wide enough to wrap
      put(8'(cnls_pkg::ChZero + $urandom_range(1, 9)));
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 5);
      repeat (n) put(8'(cnls_pkg::ChZero + $urandom_range(0, 9)));
      if ($urandom_range(0, 1)) put_suffixes($urandom_range(1, 4));
      put_ender();
    end else if (sel < 55) begin
      // real literal, occasionally with more fraction digits than are kept
      put(8'(cnls_pkg::ChZero + $urandom_range(1, 9)));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 21) : $urandom_range(0, 3);
      repeat (n) put(8'(cnls_pkg::ChZero + $urandom_range(0, 9)));
      put(cnls_pkg::ChDot);
      n = ($urandom_range(0, 99) < 15) ? $urandom_range(17, 25) : $urandom_range(0, 8);
      repeat (n) put(8'(cnls_pkg::ChZero + $urandom_range(0, 9)));
      v = $urandom_range(0, 9);
      if (v < 4) put(mix_case($urandom_range(0, 1) ? cnls_pkg::ChLoF : cnls_pkg::ChLoL));
      else if (v < 9) put_ender();
      else put_eot();
    end else if (sel < 70) begin
      // hex, long runs wrap past 64 bits
      put(cnls_pkg::ChZero);
      put(mix_case(cnls_pkg::ChLoX));
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 8);
      repeat (n) begin
        v = $urandom_range(0, 15);
        if (v < 10) put(8'(cnls_pkg::ChZero + v));
        else put(mix_case(8'(cnls_pkg::ChLoA + v - 10)));
      end
      if ($urandom_range(0, 3) == 0) put_suffixes($urandom_range(1, 3));
      put_ender();
    end else if (sel < 82) begin
      // octal, with a stray 8 or 9 now and then
      put(cnls_pkg::ChZero);
      n = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 24) : $urandom_range(1, 6);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) put(8'(cnls_pkg::ChZero + $urandom_range(8, 9)));
        else put(8'(cnls_pkg::ChZero + $urandom_range(0, 7)));
      end
      if ($urandom_range(0, 2) == 0) put_suffixes($urandom_range(1, 4));
      put_ender();
    end else if (sel < 90) begin
      // lone zero followed by something awkward
      put(cnls_pkg::ChZero);
      case ($urandom_range(0, 5))
        0: put(cnls_pkg::ChDot);
        1: put(8'(cnls_pkg::ChZero + 8));
        2: put(cnls_pkg::ChNine);
        3: begin
          put_suffixes($urandom_range(1, 4));
          put_ender();
        end
        4: put_eot();
        default: put_ender();
      endcase
    end else begin
      repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
    end
  endfunction

  // one request, then maybe a gap when the burst runs out; entered and left at a falling edge
  task automatic send_item(input logic [7:0] c, input bit eot, input bit typed,
                           input cnls_pkg::scan_result_t r);
    int g;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tuser_i  <= eot;
    row_typed       <= typed;
    row_res         <= r;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (g != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // ---------------------------------------------------------------- receiver stalls

  initial begin : sink
    int mode;
    int span;
    int tick;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(50, 300);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= 1'($urandom_range(0, 1));
          2: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready_i <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin : main
    cnls_pkg::scan_result_t none;
    logic [8:0]             item;
    none = '0;

    // directed rows; closing rows carry their result typed in
    tab("7", 1'b0);
    tab_close(8'h00, 1'b1, cnls_pkg::KIND_INT, 64'd7, 64'd0, 5'd0,
              cnls_pkg::ERR_NONE, 1'b0);
    tab("0", 1'b0);
    tab_close(".", 1'b0, cnls_pkg::KIND_INT, 64'd0, 64'd0, 5'd0,
              cnls_pkg::ERR_NONE, 1'b0);
    tab("9", 1'b0);
    tab(".", 1'b0);
    tab("2", 1'b0);
    tab("5", 1'b0);
    tab_close("L", 1'b0, cnls_pkg::KIND_LDOUBLE, 64'd9, 64'd25, 5'd2,
              cnls_pkg::ERR_NONE, 1'b1);
    tab("0", 1'b0);
    tab_close("8", 1'b0, cnls_pkg::KIND_INT, 64'd0, 64'd0, 5'd0,
              cnls_pkg::ERR_NONE, 1'b0);
    tab("u", 1'b0);
    tab("U", 1'b0);
    tab_close(" ", 1'b0, cnls_pkg::KIND_INT, 64'd8, 64'd0, 5'd0,
              cnls_pkg::ERR_BAD_SUFFIX, 1'b0);
    tab("0", 1'b0);
    tab("1", 1'b0);
    tab("7", 1'b0);
    tab_close("l", 1'b0, cnls_pkg::KIND_INT, 64'd15, 64'd0, 5'd0,
              cnls_pkg::ERR_NONE, 1'b0);
    tab("3", 1'b0);
    tab(".", 1'b0);
    tab_close(8'hff, 1'b1, cnls_pkg::KIND_DOUBLE, 64'd3, 64'd0, 5'd0,
              cnls_pkg::ERR_UNTERM, 1'b0);
    tab("1", 1'b0);
    tab("U", 1'b0);
    tab("L", 1'b0);
    tab_close(8'h00, 1'b1, cnls_pkg::KIND_ULONG, 64'd1, 64'd0, 5'd0,
              cnls_pkg::ERR_NONE, 1'b0);
    tab(8'h00, 1'b1);
    tab(8'hff, 1'b0);
    tab(8'h00, 1'b0);

    // reset once, released at a falling edge
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (char_table[i])
      send_item(char_table[i].ch, char_table[i].eot, char_table[i].typed, char_table[i].res);

    // random text, mostly well-formed literals
    while (busy_items < BusyGoal) begin
      make_literal();
      while (text_q.size() != 0) begin
        item = text_q[0];
        text_q.delete(0);
        send_item(item[7:0], item[8], 1'b0, none);
      end
    end
    // close whatever literal is still open
    send_item(8'h00, 1'b1, 1'b0, none);
    s_axis_tvalid_i <= 1'b0;

    while (pending_literals.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (pending_literals.size() != 0) bad_count++;

    if (bad_count == 0) begin
      $display("c_numeric_literal_scanner_core_tb: done, clean");
    end else begin
      $display("c_numeric_literal_scanner_core_tb: done, errors");
    end
    $finish;
  end

  // hang guard
  initial begin : guard
    #3000000;
    $display("c_numeric_literal_scanner_core_tb: done, errors");
    $finish;
  end

endmodule
